@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define JD2C_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("jd2c assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define JD2C_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("jd2c assertion failed");

`endif

@@ rtl/jd2c_pkg.sv @@
// shared widths, constants, tables and sideband types for the julian day converter
`timescale 1ns / 1ps
`default_nettype none
package jd2c_pkg;

  // field widths
  localparam int unsigned ZW    = 23;  // day number
  localparam int unsigned FW    = 24;  // day fraction
  localparam int unsigned TW    = 29;  // time of day
  localparam int unsigned DAYW  = 5;
  localparam int unsigned MONW  = 4;
  localparam int unsigned YEARW = 16;

  // internal widths
  localparam int unsigned NAW   = 25;  // alpha numerator 4z - offset
  localparam int unsigned ALW   = 8;   // alpha
  localparam int unsigned BW    = 24;  // b = a + 1524
  localparam int unsigned NCW   = 28;  // 20b - 2442
  localparam int unsigned CW    = 15;  // c
  localparam int unsigned DW    = 24;  // d = 1461c/4
  localparam int unsigned BDW   = 9;   // b - d
  localparam int unsigned NEW_W = 23;  // 10000(b - d)
  localparam int unsigned EW    = 4;   // e

  // conversion constants
  localparam int unsigned GREG_START  = 2299161;
  localparam int unsigned ALPHA_OFS   = 7468865;
  localparam int unsigned ALPHA_DIV   = 146097;
  localparam int unsigned B_OFS       = 1524;
  localparam int unsigned C_OFS       = 2442;
  localparam int unsigned C_DIV       = 7305;
  localparam int unsigned D_MUL       = 1461;
  localparam int unsigned E_MUL       = 10000;
  localparam int unsigned E_DIV       = 306001;
  localparam int unsigned E_WRAP      = 14;
  localparam int unsigned MON_OFS_LO  = 1;
  localparam int unsigned MON_OFS_HI  = 13;
  localparam int unsigned MON_FEB     = 2;
  localparam int unsigned YEAR_OFS_LO = 4716;
  localparam int unsigned YEAR_OFS_HI = 4715;

  // floor(306001 * e / 10000) for every e
  localparam logic [BDW-1:0] DAY_OFS_TBL [16] = '{
    9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd153, 9'd183, 9'd214,
    9'd244, 9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459
  };

  // sideband carried past the alpha divider
  typedef struct packed {
    logic          greg;
    logic [ZW-1:0] z;
    logic [TW-1:0] tod;
  } alpha_side_t;

  // sideband carried past the c divider
  typedef struct packed {
    logic [BW-1:0] b;
    logic [TW-1:0] tod;
  } c_side_t;

  // sideband carried past the e divider
  typedef struct packed {
    logic [BDW-1:0] bd;
    logic [CW-1:0]  c;
    logic [TW-1:0]  tod;
  } e_side_t;

endpackage
`default_nettype wire

@@ rtl/jd2c_cdiv.sv @@
// three stage divider by a constant: reciprocal multiply, remainder, correction
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module jd2c_cdiv #(
  parameter int unsigned NW = jd2c_pkg::NAW,
  parameter int unsigned QW = jd2c_pkg::ALW,
  parameter int unsigned K  = jd2c_pkg::ALPHA_DIV,
  parameter int unsigned SW = $bits(jd2c_pkg::alpha_side_t)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          vld_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [SW-1:0] side_i,
  output logic               vld_o,
  output logic [QW-1:0]      quo_o,
  output logic [SW-1:0]      side_o
);

  // reciprocal floor(2^NW / K): estimate is the quotient or one below it
  localparam longint unsigned MulL = (64'd1 << NW) / K;
  localparam int unsigned     MulW = $clog2(MulL + 1);
  localparam int unsigned     PW   = NW + MulW;
  localparam int unsigned     RW   = $clog2(2 * K);
  localparam logic [MulW-1:0] Mul  = MulW'(MulL);
  localparam logic [NW-1:0]   KN   = NW'(K);
  localparam logic [RW-1:0]   KR   = RW'(K);

  logic          va_q, vb_q, vc_q;
  logic [PW-1:0] prod_d, prod_q;
  logic [NW-1:0] num_q;
  logic [SW-1:0] sa_q, sb_q, sc_q;
  logic [QW-1:0] q0_d, q0_q, quo_d, quo_q;
  logic [NW-1:0] rem_full;
  logic [RW-1:0] rem_d, rem_q;

  // stage a: reciprocal product
  assign prod_d = PW'(num_i) * PW'(Mul);

  // stage b: estimate and remainder
  assign q0_d     = QW'(prod_q >> NW);
  assign rem_full = num_q - (NW'(q0_d) * KN);
  assign rem_d    = rem_full[RW-1:0];

  // stage c: one step correction
  assign quo_d = q0_q + QW'(rem_q >= KR);

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= vld_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    num_q  <= num_i;
    sa_q   <= side_i;
    q0_q   <= q0_d;
    rem_q  <= rem_d;
    sb_q   <= sa_q;
    quo_q  <= quo_d;
    sc_q   <= sb_q;
  end

  assign vld_o  = vc_q;
  assign quo_o  = quo_q;
  assign side_o = sc_q;

  // estimate is never more than one below the quotient
  `JD2C_ASSERT(cdiv_rem_range_a, !vb_q || ({1'b0, rem_q} < ({1'b0, KR} << 1)))
  // a transaction entering on vld_i leaves on vld_o after passing stages a, b and c
  `JD2C_ASSERT_NEXT(cdiv_latency_a, vld_i, ##2 vld_o)

endmodule
`default_nettype wire

@@ rtl/jd2c_finish.sv @@
// final stage: day, month and year from b - d, c and e, registered to the outputs
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module jd2c_finish (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           vld_i,
  input  wire logic [jd2c_pkg::EW-1:0]        e_i,
  input  wire jd2c_pkg::e_side_t              side_i,
  output logic                                done_o,
  output logic [jd2c_pkg::DAYW-1:0]           cal_day_o,
  output logic [jd2c_pkg::MONW-1:0]           cal_month_o,
  output logic signed [jd2c_pkg::YEARW-1:0]   cal_year_o,
  output logic [jd2c_pkg::TW-1:0]             time_of_day_o
);

  localparam logic [jd2c_pkg::EW-1:0]    EW_WRAP    = jd2c_pkg::EW'(jd2c_pkg::E_WRAP);
  localparam logic [jd2c_pkg::MONW-1:0]  MONW_OFS_LO = jd2c_pkg::MONW'(jd2c_pkg::MON_OFS_LO);
  localparam logic [jd2c_pkg::MONW-1:0]  MONW_OFS_HI = jd2c_pkg::MONW'(jd2c_pkg::MON_OFS_HI);
  localparam logic [jd2c_pkg::MONW-1:0]  MON_FEB     = jd2c_pkg::MONW'(jd2c_pkg::MON_FEB);

  logic                          done_q;
  logic [jd2c_pkg::DAYW-1:0]     day_d, day_q;
  logic [jd2c_pkg::MONW-1:0]     mon_d, mon_q;
  logic [jd2c_pkg::YEARW-1:0]    year_d, year_q;
  logic [jd2c_pkg::TW-1:0]       tod_q;
  logic [jd2c_pkg::BDW-1:0]      day_full;

  // day of month from the table of month starts
  assign day_full = side_i.bd - jd2c_pkg::DAY_OFS_TBL[e_i];
  assign day_d    = day_full[jd2c_pkg::DAYW-1:0];

  // month wraps after december
  assign mon_d = (e_i < EW_WRAP) ? (e_i - MONW_OFS_LO) : (e_i - MONW_OFS_HI);

  // january and february belong to the following year
  assign year_d = jd2c_pkg::YEARW'(side_i.c) -
                  ((mon_d > MON_FEB) ? jd2c_pkg::YEARW'(jd2c_pkg::YEAR_OFS_LO)
                                     : jd2c_pkg::YEARW'(jd2c_pkg::YEAR_OFS_HI));

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_i;
    end
  end

  // result fields
  always_ff @(posedge clk_i) begin
    day_q  <= day_d;
    mon_q  <= mon_d;
    year_q <= year_d;
    tod_q  <= side_i.tod;
  end

  assign done_o        = done_q;
  assign cal_day_o     = day_q;
  assign cal_month_o   = mon_q;
  assign cal_year_o    = $signed(year_q);
  assign time_of_day_o = tod_q;

  // every delivered date has a nonzero day and a month from 1 to 12
  `JD2C_ASSERT(fin_date_range_a,
      !done_o || (cal_day_o != '0 && cal_month_o != '0 && cal_month_o <= 4'd12))
  `JD2C_ASSERT(fin_e_range_a, !vld_i || (e_i >= 4'd4))

endmodule
`default_nettype wire

@@ rtl/calendar_date_from_julian_day_top.sv @@
// top level of the julian day to calendar date converter
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Converts a day number Z = floor(JD + 0.5) and a day fraction into day, month,
// astronomical year and time of day (fraction times 24), with the Gregorian
// correction from day number 2299161 upward. busy is never raised: a
// transaction may be started in every cycle, and its result appears on the
// outputs with done_o high, in start order. The receiver cannot stall the
// outputs; each result is shown for one cycle only. Each transaction passes
// in turn the alpha divider, a stage forming b, the c divider, a stage forming
// b - d, one forming 10000(b - d), the e divider and the output register;
// each constant divider has three stages.
module calendar_date_from_julian_day_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [jd2c_pkg::ZW-1:0]       day_number_i,
  input  wire logic [jd2c_pkg::FW-1:0]       day_fraction_i,
  output logic                               done_o,
  output logic [jd2c_pkg::DAYW-1:0]          cal_day_o,
  output logic [jd2c_pkg::MONW-1:0]          cal_month_o,
  output logic signed [jd2c_pkg::YEARW-1:0]  cal_year_o,
  output logic [jd2c_pkg::TW-1:0]            time_of_day_o
);

  localparam int unsigned Latency = 13;

  logic                        in_vld;
  logic                        greg;
  logic [jd2c_pkg::NAW-1:0]    na;
  jd2c_pkg::alpha_side_t       side_a_in, side_a_out;
  logic                        alpha_vld;
  logic [jd2c_pkg::ALW-1:0]    alpha;

  logic                        vb_q;
  logic [jd2c_pkg::BW-1:0]     a_val, b_d, b_q;
  logic [jd2c_pkg::TW-1:0]     tod_b_q;
  logic [jd2c_pkg::NCW-1:0]    nc;
  jd2c_pkg::c_side_t           side_c_in, side_c_out;
  logic                        c_vld;
  logic [jd2c_pkg::CW-1:0]     c_val;

  logic                        vd_q;
  logic [jd2c_pkg::DW+1:0]     d_full;
  logic [jd2c_pkg::DW-1:0]     d_val;
  logic [jd2c_pkg::BW-1:0]     bd_full;
  jd2c_pkg::e_side_t           side_d_d, side_d_q;

  logic                        vn_q;
  logic [jd2c_pkg::NEW_W-1:0]  ne_d, ne_q;
  jd2c_pkg::e_side_t           side_n_q, side_e_out;
  logic                        e_vld;
  logic [jd2c_pkg::EW-1:0]     e_val;

  // every start is taken
  assign busy   = 1'b0;
  assign in_vld = start && !busy;

  // gregorian test, alpha numerator and time of day (fraction times 24)
  assign greg = day_number_i >= jd2c_pkg::ZW'(jd2c_pkg::GREG_START);
  assign na   = greg ? (jd2c_pkg::NAW'({day_number_i, 2'b00}) -
                        jd2c_pkg::NAW'(jd2c_pkg::ALPHA_OFS))
                     : '0;
  assign side_a_in.greg = greg;
  assign side_a_in.z    = day_number_i;
  assign side_a_in.tod  = (jd2c_pkg::TW'(day_fraction_i) << 4) +
                          (jd2c_pkg::TW'(day_fraction_i) << 3);

  jd2c_cdiv #(
    .NW (jd2c_pkg::NAW),
    .QW (jd2c_pkg::ALW),
    .K  (jd2c_pkg::ALPHA_DIV),
    .SW ($bits(jd2c_pkg::alpha_side_t))
  ) u_div_alpha (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (in_vld),
    .num_i  (na),
    .side_i (side_a_in),
    .vld_o  (alpha_vld),
    .quo_o  (alpha),
    .side_o (side_a_out)
  );

  // b stage: calendar correction and offset
  assign a_val = side_a_out.greg
               ? (jd2c_pkg::BW'(side_a_out.z) + jd2c_pkg::BW'(1) + jd2c_pkg::BW'(alpha)
                  - jd2c_pkg::BW'(alpha >> 2))
               : jd2c_pkg::BW'(side_a_out.z);
  assign b_d   = a_val + jd2c_pkg::BW'(jd2c_pkg::B_OFS);

  // c numerator 20b - 2442
  assign nc = (jd2c_pkg::NCW'(b_q) << 4) + (jd2c_pkg::NCW'(b_q) << 2) -
              jd2c_pkg::NCW'(jd2c_pkg::C_OFS);
  assign side_c_in.b   = b_q;
  assign side_c_in.tod = tod_b_q;

  jd2c_cdiv #(
    .NW (jd2c_pkg::NCW),
    .QW (jd2c_pkg::CW),
    .K  (jd2c_pkg::C_DIV),
    .SW ($bits(jd2c_pkg::c_side_t))
  ) u_div_c (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (vb_q),
    .num_i  (nc),
    .side_i (side_c_in),
    .vld_o  (c_vld),
    .quo_o  (c_val),
    .side_o (side_c_out)
  );

  // d stage: day count of whole years, then days into the year
  assign d_full        = 26'(c_val) * 26'(jd2c_pkg::D_MUL);
  assign d_val         = d_full[jd2c_pkg::DW+1:2];
  assign bd_full       = side_c_out.b - d_val;
  assign side_d_d.bd   = bd_full[jd2c_pkg::BDW-1:0];
  assign side_d_d.c    = c_val;
  assign side_d_d.tod  = side_c_out.tod;

  // e numerator 10000(b - d)
  assign ne_d = jd2c_pkg::NEW_W'(side_d_q.bd) * jd2c_pkg::NEW_W'(jd2c_pkg::E_MUL);

  jd2c_cdiv #(
    .NW (jd2c_pkg::NEW_W),
    .QW (jd2c_pkg::EW),
    .K  (jd2c_pkg::E_DIV),
    .SW ($bits(jd2c_pkg::e_side_t))
  ) u_div_e (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (vn_q),
    .num_i  (ne_q),
    .side_i (side_n_q),
    .vld_o  (e_vld),
    .quo_o  (e_val),
    .side_o (side_e_out)
  );

  jd2c_finish u_finish (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .vld_i         (e_vld),
    .e_i           (e_val),
    .side_i        (side_e_out),
    .done_o        (done_o),
    .cal_day_o     (cal_day_o),
    .cal_month_o   (cal_month_o),
    .cal_year_o    (cal_year_o),
    .time_of_day_o (time_of_day_o)
  );

  // valid bits of the glue stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
      vd_q <= 1'b0;
      vn_q <= 1'b0;
    end else begin
      vb_q <= alpha_vld;
      vd_q <= c_vld;
      vn_q <= vd_q;
    end
  end

  // payload of the glue stages
  always_ff @(posedge clk_i) begin
    b_q      <= b_d;
    tod_b_q  <= side_a_out.tod;
    side_d_q <= side_d_d;
    ne_q     <= ne_d;
    side_n_q <= side_d_q;
  end

  // every start yields exactly one result, and done_o is not raised without a start
  `JD2C_ASSERT(top_result_a, start |-> ##Latency done_o)
  `JD2C_ASSERT(top_no_extra_a, !start |-> ##Latency !done_o)

endmodule
`default_nettype wire
